>>> hw/rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, widths and constants of the Taylor sine/cosine pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  // Port field widths
  localparam int unsigned AngleW = 32;  // Q4.28 angle
  localparam int unsigned ValueW = 32;  // Q2.30 result

  // Angle work width: Q28 with room for the added pi/2
  localparam int unsigned XW = 34;

  // Term magnitude, x^2, product and running sum widths
  localparam int unsigned MagW  = 32;
  localparam int unsigned X2W   = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned SumW  = 36;
  localparam int unsigned SatW  = SumW + 2;

  // Fraction bits of the angle format
  localparam int unsigned FracW = 28;

  // Angle constants in Q28, rounded to nearest
  localparam logic signed [XW-1:0] Q28Pi     = XW'(32'sd843314857);
  localparam logic signed [XW-1:0] Q28TwoPi  = XW'(32'sd1686629713);
  localparam logic signed [XW-1:0] Q28HalfPi = XW'(32'sd421657428);

  // Half an LSB of Q28 for rounding the square
  localparam logic [ProdW-1:0] SqRound = ProdW'(1) << (FracW - 1);

  // Saturation limits of the Q30 result
  localparam logic signed [SatW-1:0] SatHi = SatW'(32'sh7FFF_FFFF);
  localparam logic signed [SatW-1:0] SatLo = SatW'(32'sh8000_0000);

  // Mode codes
  localparam logic ModeSin = 1'b0;
  localparam logic ModeCos = 1'b1;

  typedef logic [MagW-1:0]         mag_t;
  typedef logic [X2W-1:0]          x2_t;
  typedef logic signed [SumW-1:0]  sum_t;

  // One series term in flight: sign/magnitude, x^2, and the sum of earlier terms
  typedef struct packed {
    mag_t mag;
    logic neg;
    x2_t  x2;
    sum_t sum;
  } term_t;

  // Signed value of a sign/magnitude term, widened to the sum width
  function automatic sum_t term_value(mag_t mag, logic neg);
    sum_t ext;
    ext = $signed({{(SumW - MagW){1'b0}}, mag});
    return neg ? -ext : ext;
  endfunction

  // Trailing zero count of a small constant (elaboration use)
  function automatic int unsigned ctz(int unsigned k);
    int unsigned n;
    logic        done;
    n    = 0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!done) begin
        if (k[i]) begin
          done = 1'b1;
        end else begin
          n = n + 1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tsc_in_if.sv
// ----------------------------------------------------------------------------
// tsc_in_if
// Input channel: valid/ready handshake carrying mode and angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic signed [tsc_pkg::AngleW-1:0]   angle;

  modport source (output valid, output mode, output angle, input ready);
  modport sink   (input valid, input mode, input angle, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tsc_out_if.sv
// ----------------------------------------------------------------------------
// tsc_out_if
// Output channel: valid/ready handshake carrying the sine/cosine value.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsc_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tsc_term.sv
// ----------------------------------------------------------------------------
// tsc_term
// One series step, four stages: adds the incoming term to the sum and forms
// the next term -t * x^2 / (K * 2^28), rounded half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_term #(
  parameter int unsigned K = 6
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire tsc_pkg::term_t  term_i,
  output tsc_pkg::term_t       term_o
);

  // K = M * 2^Tz: the power of two folds into the shift, M is a small odd divisor
  localparam int unsigned Tz = tsc_pkg::ctz(K);
  localparam int unsigned M  = K >> Tz;
  localparam int unsigned Sh = tsc_pkg::FracW + Tz;

  localparam logic [tsc_pkg::ProdW-1:0] Round = tsc_pkg::ProdW'(K) << (tsc_pkg::FracW - 1);
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / M);
  localparam logic [31:0] MulM  = 32'(M);

  // Stage 1: magnitude product, sum of earlier terms
  logic [tsc_pkg::ProdW-1:0] prod_q;
  logic                      neg1_q;
  tsc_pkg::x2_t              x21_q;
  tsc_pkg::sum_t             sum1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= tsc_pkg::ProdW'(term_i.mag) * tsc_pkg::ProdW'(term_i.x2);
      neg1_q <= term_i.neg;
      x21_q  <= term_i.x2;
      sum1_q <= term_i.sum + tsc_pkg::term_value(term_i.mag, term_i.neg);
    end
  end

  // Stage 2: round and drop the power-of-two part of the divisor
  logic [31:0]   n2_q;
  logic          neg2_q;
  tsc_pkg::x2_t  x22_q;
  tsc_pkg::sum_t sum2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q   <= 32'((prod_q + Round) >> Sh);
      neg2_q <= neg1_q;
      x22_q  <= x21_q;
      sum2_q <= sum1_q;
    end
  end

  // Stage 3: quotient estimate by reciprocal, low by at most one
  logic [31:0]   qe3_q;
  logic [31:0]   n3_q;
  logic          neg3_q;
  tsc_pkg::x2_t  x23_q;
  tsc_pkg::sum_t sum3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe3_q  <= 32'((64'(n2_q) * 64'(Recip)) >> 32);
      n3_q   <= n2_q;
      neg3_q <= neg2_q;
      x23_q  <= x22_q;
      sum3_q <= sum2_q;
    end
  end

  // Stage 4: remainder check fixes the estimate; the sign flips each term
  logic [31:0] rem;
  logic [31:0] q;

  assign rem = n3_q - (qe3_q * MulM);
  assign q   = qe3_q + 32'(rem >= MulM);

  tsc_pkg::term_t term_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q.mag <= tsc_pkg::MagW'(q);
      term_q.neg <= ~neg3_q;
      term_q.x2  <= x23_q;
      term_q.sum <= sum3_q;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

>>> hw/rtl/taylor_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Sine/cosine of a Q4.28 angle by a seventh-order Taylor polynomial, Q2.30 out.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the skid buffer is empty. The
// pipeline holds these stages in order: one stage adds pi/2 for cosine, two
// stages fold the angle into [-pi, pi] one 2*pi step each, one stage squares
// the magnitude, one stage rounds x^2, three term units of four stages each
// form x^3/6, x^5/120 and x^7/5040 (multiply, round, reciprocal estimate,
// correction), one stage adds the last term, and the output register
// saturates the Q30 result. A one-item skid buffer behind the output
// register lets the pipeline keep accepting while a result waits; input
// ready drops only while that buffer is full. Results leave in acceptance
// order. The block keeps no state between items.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsc_in_if.sink     in_i,
  tsc_out_if.source  out_o
);

  localparam int unsigned NStages = 18;
  localparam int unsigned LastStg = NStages - 1;

  // Fold one 2*pi step toward [-pi, pi]
  function automatic logic signed [tsc_pkg::XW-1:0] fold(
    logic signed [tsc_pkg::XW-1:0] x
  );
    logic signed [tsc_pkg::XW-1:0] r;
    if (x > tsc_pkg::Q28Pi) begin
      r = x - tsc_pkg::Q28TwoPi;
    end else if (x < -tsc_pkg::Q28Pi) begin
      r = x + tsc_pkg::Q28TwoPi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Pipeline control: the whole pipe advances while the skid buffer is empty
  logic               en;
  logic [LastStg:0]   valid_q;
  logic               skid_valid_q;
  logic               out_valid_q;
  logic               emit;

  assign en         = ~skid_valid_q;
  assign in_i.ready = en;
  assign emit       = en & valid_q[LastStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LastStg-1:0], in_i.valid};
    end
  end

  // Stage 0: cosine offset
  logic signed [tsc_pkg::XW-1:0] xa_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= tsc_pkg::XW'(in_i.angle)
            + ((in_i.mode == tsc_pkg::ModeCos) ? tsc_pkg::Q28HalfPi : '0);
    end
  end

  // Stages 1 and 2: range folding
  logic signed [tsc_pkg::XW-1:0] xb_q;
  logic signed [tsc_pkg::XW-1:0] xc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xb_q <= fold(xa_q);
      xc_q <= fold(xb_q);
    end
  end

  // Stage 3: sign/magnitude and square
  logic signed [tsc_pkg::XW-1:0] xc_neg;
  tsc_pkg::mag_t                 mag3_d;
  tsc_pkg::mag_t                 mag3_q;
  logic                          neg3_q;
  logic [tsc_pkg::ProdW-1:0]     sq3_q;

  assign xc_neg = -xc_q;
  assign mag3_d = tsc_pkg::MagW'(xc_q[tsc_pkg::XW-1] ? xc_neg : xc_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag3_q <= mag3_d;
      neg3_q <= xc_q[tsc_pkg::XW-1];
      sq3_q  <= tsc_pkg::ProdW'(mag3_d) * tsc_pkg::ProdW'(mag3_d);
    end
  end

  // Stage 4: x^2 back to Q28 (half up), first term is x itself
  tsc_pkg::term_t t0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q.mag <= mag3_q;
      t0_q.neg <= neg3_q;
      t0_q.x2  <= tsc_pkg::X2W'((sq3_q + tsc_pkg::SqRound) >> tsc_pkg::FracW);
      t0_q.sum <= '0;
    end
  end

  // Stages 5 to 16: the three series steps
  tsc_pkg::term_t t1;
  tsc_pkg::term_t t2;
  tsc_pkg::term_t t3;

  tsc_term #(.K(6)) u_term3 (
    .clk_i  (clk_i),
    .en_i   (en),
    .term_i (t0_q),
    .term_o (t1)
  );

  tsc_term #(.K(20)) u_term5 (
    .clk_i  (clk_i),
    .en_i   (en),
    .term_i (t1),
    .term_o (t2)
  );

  tsc_term #(.K(42)) u_term7 (
    .clk_i  (clk_i),
    .en_i   (en),
    .term_i (t2),
    .term_o (t3)
  );

  // Stage 17: add the last term
  tsc_pkg::sum_t sumf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sumf_q <= t3.sum + tsc_pkg::term_value(t3.mag, t3.neg);
    end
  end

  // Q28 to Q30 and saturate
  logic signed [tsc_pkg::SatW-1:0]   sum_q30;
  logic signed [tsc_pkg::ValueW-1:0] sat_val;

  assign sum_q30 = {sumf_q, 2'b00};

  always_comb begin
    if (sum_q30 > tsc_pkg::SatHi) begin
      sat_val = tsc_pkg::ValueW'(tsc_pkg::SatHi);
    end else if (sum_q30 < tsc_pkg::SatLo) begin
      sat_val = tsc_pkg::ValueW'(tsc_pkg::SatLo);
    end else begin
      sat_val = tsc_pkg::ValueW'(sum_q30);
    end
  end

  // Output register and skid buffer
  logic signed [tsc_pkg::ValueW-1:0] out_value_q;
  logic signed [tsc_pkg::ValueW-1:0] skid_value_q;
  logic                              out_load;
  logic                              skid_load;

  assign out_load  = ~out_valid_q | out_o.ready;
  assign skid_load = emit & out_valid_q & ~out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= skid_valid_q | emit;
      end
      if (skid_load) begin
        skid_valid_q <= 1'b1;
      end else if (skid_valid_q && out_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= skid_valid_q ? skid_value_q : sat_val;
    end
    if (skid_load) begin
      skid_value_q <= sat_val;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

endmodule

`default_nettype wire

>>> hw/rtl/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the Taylor sine/cosine block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [tsc_pkg::ValueW-1:0]   out_value_i
);

  // The polynomial stays near [-1, 1] over [-pi, pi]; 1.25 in Q30 is a safe bound
  localparam logic signed [tsc_pkg::ValueW-1:0] Lim = 32'sd1342177280;

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("result item changed while stalled");

  // Results lie within the reach of the folded polynomial
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_value_i <= Lim) && (out_value_i >= -Lim))
    else $error("result item out of range");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result item right after reset");

endmodule

bind taylor_sine_cosine_top tsc_checker u_tsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Taylor sine/cosine pipeline. Each accepted
// angle is predicted in fixed point and queued, and each result is compared
// in order. Both channels stall at random, and the output side holds off
// once for a long stretch so the pipeline fills and backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tsc_pkg::*;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [ValueW-1:0] value_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts sine/cosine values and checks results in order
  // ---------------------------------------------------------------------------
  class sincos_scoreboard;
    localparam longint PiQ28     = 843314857;
    localparam longint TwoPiQ28  = 1686629713;
    localparam longint HalfPiQ28 = 421657428;
    localparam longint OneQ28    = 268435456;

    typedef struct {
      logic   mode;
      angle_t angle;
      value_t value;
    } expected_value_t;

    expected_value_t expected_values[$];
    int unsigned     n_sin;
    int unsigned     n_cos;
    int unsigned     n_checked;
    int unsigned     n_errors;

    function new();
      n_sin     = 0;
      n_cos     = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    // Next series term: -(term * x2) / (k * 2^28), magnitude rounded half away
    static function longint series_term(longint term, longint unsigned x2,
                                        longint unsigned k);
      longint unsigned mag;
      longint unsigned den;
      longint unsigned q;
      mag = (term < 0) ? longint'(-term) : longint'(term);
      den = k * OneQ28;
      q   = (mag * x2 + den / 2) / den;
      return (term < 0) ? longint'(q) : -longint'(q);
    endfunction

    // Expected Q2.30 value for one angle and mode
    static function value_t taylor_value(logic mode, angle_t angle);
      longint          x;
      longint          term;
      longint          acc;
      longint unsigned mag;
      longint unsigned x2;
      x = longint'(angle);
      if (mode == ModeCos) x += HalfPiQ28;
      // fold into [-pi, pi]; exactly +-pi stays put
      for (int i = 0; i < 3; i++) begin
        if (x > PiQ28) begin
          x -= TwoPiQ28;
        end else if (x < -PiQ28) begin
          x += TwoPiQ28;
        end
      end
      mag  = (x < 0) ? longint'(-x) : longint'(x);
      x2   = (mag * mag + OneQ28 / 2) / OneQ28;
      term = x;
      acc  = x;
      term = series_term(term, x2, 6);
      acc += term;
      term = series_term(term, x2, 20);
      acc += term;
      term = series_term(term, x2, 42);
      acc += term;
      acc  = acc * 4;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[ValueW-1:0];
    endfunction

    // One accepted input item
    function void note_angle(logic mode, angle_t angle);
      expected_value_t e;
      e.mode  = mode;
      e.angle = angle;
      e.value = taylor_value(mode, angle);
      expected_values.push_back(e);
      if (mode == ModeCos) n_cos++;
      else n_sin++;
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // One accepted result item
    task check_value(value_t value);
      expected_value_t e;
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", value));
      end else begin
        e = expected_values.pop_front();
        n_checked++;
        if (value !== e.value)
          report_mismatch($sformatf("mode %0d angle %h: value %h, expected %h",
                                    e.mode, e.angle, value, e.value));
      end
    endtask

    task finish_check();
      if (expected_values.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  tsc_in_if  in_ch();
  tsc_out_if out_ch();

  taylor_sine_cosine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sincos_scoreboard sb = new();

  int unsigned n_sent;
  bit          in_calm;
  int unsigned calm_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(logic mode, angle_t angle);
    int gap;
    if (calm_left == 0) begin
      in_calm   = !in_calm;
      calm_left = $urandom_range(20, 150);
    end else begin
      calm_left--;
    end
    gap = (in_calm || $urandom_range(0, 1)) ? 0 : idle_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.angle <= angle;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_angle(mode, angle);
    n_sent++;
  endtask

  task automatic send_both(longint v);
    send_item(ModeSin, v[AngleW-1:0]);
    send_item(ModeCos, v[AngleW-1:0]);
  endtask

  // Random angle: full range, one turn, near fold edges, or tiny
  function automatic angle_t random_angle();
    longint edges[6];
    longint v;
    int     r;
    edges[0] = sincos_scoreboard::PiQ28;
    edges[1] = -sincos_scoreboard::PiQ28;
    edges[2] = sincos_scoreboard::HalfPiQ28;
    edges[3] = -sincos_scoreboard::PiQ28 - sincos_scoreboard::HalfPiQ28;
    edges[4] = sincos_scoreboard::TwoPiQ28 + sincos_scoreboard::HalfPiQ28;
    edges[5] = -sincos_scoreboard::TwoPiQ28 - sincos_scoreboard::HalfPiQ28;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = longint'($urandom());
    end else if (r < 70) begin
      v = longint'($urandom_range(0, 2 * 843314857)) - sincos_scoreboard::PiQ28;
    end else if (r < 90) begin
      v = edges[$urandom_range(0, 5)] + longint'($urandom_range(0, 16)) - 8;
    end else begin
      v = longint'($urandom_range(0, 4095));
      if ($urandom_range(0, 1)) v = -v;
    end
    return v[AngleW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Output ready: random stalls, calm stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : out_ready_drive
    int stall_left;
    int phase_left;
    bit out_calm;
    bit held;
    stall_left = 0;
    phase_left = 100;
    out_calm   = 1'b0;
    held       = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_sent >= 300) begin
        held       = 1'b1;
        stall_left = 400;
      end
      if (phase_left == 0) begin
        out_calm   = !out_calm;
        phase_left = $urandom_range(50, 400);
      end else begin
        phase_left--;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) stall_left = idle_length();
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_value(out_ch.value);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    n_sent    = 0;
    in_calm   = 1'b0;
    calm_left = 10;
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= ModeSin;
    in_ch.angle <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, LSBs, range ends, exact and just-past fold edges
    send_both(0);
    send_both(1);
    send_both(-1);
    send_both(64'sh7FFF_FFFF);
    send_both(-64'sh8000_0000);
    send_both(sincos_scoreboard::PiQ28);
    send_both(-sincos_scoreboard::PiQ28);
    send_both(sincos_scoreboard::PiQ28 + 1);
    send_both(-sincos_scoreboard::PiQ28 - 1);
    send_both(sincos_scoreboard::HalfPiQ28);
    send_both(sincos_scoreboard::HalfPiQ28 + 1);
    send_both(-sincos_scoreboard::PiQ28 - sincos_scoreboard::HalfPiQ28 - 1);

    // random part
    repeat (1250) send_item(logic'($urandom_range(0, 1)), random_angle());
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    sb.finish_check();

    $display("Covered %0d sine and %0d cosine items, %0d results checked.",
             sb.n_sin, sb.n_cos, sb.n_checked);
    $display("Included fold edges, range ends and a long output hold-off.");
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3_000_000;
    $display("Watchdog expired with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_in_if.sv
hw/rtl/tsc_out_if.sv
hw/rtl/tsc_term.sv
hw/rtl/taylor_sine_cosine_top.sv
hw/rtl/tsc_checker.sv
tb/testbench.sv
